### hdl/pffl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pffl_pkg - page frame free list allocator package
// Shared types, field widths and codes for the allocator.
// ----------------------------------------------------------------------------
package pffl_pkg;

  localparam int ADDR_W  = 28;
  localparam int COUNT_W = 17;
  localparam int KIND_W  = 2;
  localparam int CLASS_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_INIT  = 2'd0,
    KIND_ALLOC = 2'd1,
    KIND_FREE  = 2'd2,
    KIND_NOP   = 2'd3
  } kind_t;

  typedef enum logic [CLASS_W-1:0] {
    CLASS_FREE = 2'd0,
    CLASS_USED = 2'd1,
    CLASS_RESV = 2'd2,
    CLASS_BAD  = 2'd3
  } page_class_t;

  typedef enum logic [1:0] {
    FS_FREE   = 2'd0,
    FS_USED   = 2'd1,
    FS_RESV   = 2'd2,
    FS_LISTED = 2'd3
  } frame_state_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } ctl_state_t;

  typedef struct packed {
    logic capture;
    logic commit;
    logic clear_step;
  } ctl_cmd_t;

  typedef struct packed {
    logic clear_last;
  } dp_status_t;

endpackage : pffl_pkg
`default_nettype wire

### hdl/pffl_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pffl_if - allocator channel interfaces
// Request and result channels, valid/ready handshake with payload.
// ----------------------------------------------------------------------------
interface pffl_req_if import pffl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [ADDR_W-1:0]  phys_address;
  logic [COUNT_W-1:0] page_count;
  logic [CLASS_W-1:0] page_class;

  modport source (output valid, kind, phys_address, page_count, page_class, input ready);
  modport sink (input valid, kind, phys_address, page_count, page_class, output ready);
endinterface : pffl_req_if

interface pffl_rsp_if import pffl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ADDR_W-1:0]  result_address;
  logic               ok;
  logic [COUNT_W-1:0] available;

  modport source (output valid, result_address, ok, available, input ready);
  modport sink (input valid, result_address, ok, available, output ready);
endinterface : pffl_rsp_if
`default_nettype wire

### hdl/pffl_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pffl_ctrl - allocator controller
// Sequences the clearing pass, request capture and commit, and owns the
// result valid flag.
// ----------------------------------------------------------------------------
module pffl_ctrl import pffl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output ctl_cmd_t   cmd,
  input  dp_status_t status
);

  ctl_state_t state, state_next;
  logic       out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    cmd            = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.commit = !out_valid || out_ready;
        if (cmd.commit) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule : pffl_ctrl
`default_nettype wire

### hdl/pffl_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pffl_datapath - allocator datapath
// Frame state table, FIFO free list, queue pointers, counters and the
// result register.
// ----------------------------------------------------------------------------
module pffl_datapath import pffl_pkg::*; #(
  parameter int NUM_PAGES = 65536,
  parameter int PAGE_BITS = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  ctl_cmd_t           cmd,
  output dp_status_t         status,
  input  logic [KIND_W-1:0]  kind,
  input  logic [ADDR_W-1:0]  phys_address,
  input  logic [COUNT_W-1:0] page_count,
  input  logic [CLASS_W-1:0] page_class,
  output logic [ADDR_W-1:0]  result_address,
  output logic               ok,
  output logic [COUNT_W-1:0] available
);

  localparam int IW = $clog2(NUM_PAGES);
  localparam int CW = $clog2(NUM_PAGES + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_PAGES - 1);

  frame_state_t frame_mem [NUM_PAGES];
  logic [IW-1:0] queue_mem [NUM_PAGES];

  logic [IW-1:0] queue_head, queue_head_next;
  logic [IW-1:0] queue_tail, queue_tail_next;
  logic [CW-1:0] free_pages, free_pages_next;
  logic [CW-1:0] page_limit, page_limit_next;
  logic [IW-1:0] clear_cnt;

  kind_t         kind_r;
  page_class_t   class_r;
  logic [IW-1:0] idx_r;
  logic          in_range_r;
  logic          one_r;
  frame_state_t  fs_rd;
  logic [IW-1:0] q_rd;

  logic [31:0]   pn_wide;
  logic [IW-1:0] idx_in;
  logic [CW-1:0] lim_cand;
  logic [63:0]   addr_wide;
  logic [31:0]   avail_wide;

  logic          fs_we;
  logic [IW-1:0] fs_waddr;
  frame_state_t  fs_wdata;
  logic          push, pop, raise, ok_c;
  logic [ADDR_W-1:0] addr_c;

  function automatic logic [IW-1:0] ptr_next(input logic [IW-1:0] p);
    return (p == LAST_IDX) ? '0 : p + IW'(1);
  endfunction

  assign pn_wide   = 32'(phys_address >> PAGE_BITS);
  assign idx_in    = pn_wide[IW-1:0];
  assign lim_cand  = CW'(idx_r) + CW'(1);
  assign addr_wide = 64'(q_rd) << PAGE_BITS;
  assign status.clear_last = (clear_cnt == LAST_IDX);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r     <= kind_t'(kind);
      class_r    <= page_class_t'(page_class);
      idx_r      <= idx_in;
      in_range_r <= (pn_wide < 32'(NUM_PAGES));
      one_r      <= (page_count == COUNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (fs_we) frame_mem[fs_waddr] <= fs_wdata;
    if (cmd.capture) fs_rd <= frame_mem[idx_in];
  end

  always_ff @(posedge clk) begin
    if (push) queue_mem[queue_tail] <= idx_r;
    if (cmd.capture) q_rd <= queue_mem[queue_head];
  end

  always_comb begin
    push     = 1'b0;
    pop      = 1'b0;
    raise    = 1'b0;
    ok_c     = 1'b0;
    addr_c   = '0;
    fs_we    = 1'b0;
    fs_waddr = idx_r;
    fs_wdata = FS_LISTED;
    if (cmd.clear_step) begin
      fs_we    = 1'b1;
      fs_waddr = clear_cnt;
      fs_wdata = FS_FREE;
    end else if (cmd.commit) begin
      case (kind_r)
        KIND_INIT: begin
          if (in_range_r && class_r != CLASS_BAD) begin
            if (fs_rd == FS_LISTED) begin
              ok_c = (class_r == CLASS_FREE);
            end else begin
              ok_c  = 1'b1;
              fs_we = 1'b1;
              case (class_r)
                CLASS_FREE: begin
                  fs_wdata = FS_LISTED;
                  push     = 1'b1;
                end
                CLASS_USED: fs_wdata = FS_USED;
                default:    fs_wdata = FS_RESV;
              endcase
            end
            raise = ok_c;
          end
        end
        KIND_ALLOC: begin
          if (one_r && free_pages != '0) begin
            ok_c     = 1'b1;
            pop      = 1'b1;
            fs_we    = 1'b1;
            fs_waddr = q_rd;
            fs_wdata = FS_USED;
            addr_c   = addr_wide[ADDR_W-1:0];
          end
        end
        KIND_FREE: begin
          if (one_r && in_range_r && CW'(idx_r) < page_limit &&
              (fs_rd == FS_USED || fs_rd == FS_RESV)) begin
            ok_c  = 1'b1;
            fs_we = 1'b1;
            push  = 1'b1;
          end
        end
        default: ok_c = 1'b0;
      endcase
    end
  end

  always_comb begin
    queue_head_next = pop ? ptr_next(queue_head) : queue_head;
    queue_tail_next = push ? ptr_next(queue_tail) : queue_tail;
    free_pages_next = free_pages;
    if (push) free_pages_next = free_pages + CW'(1);
    if (pop)  free_pages_next = free_pages - CW'(1);
    page_limit_next = (raise && lim_cand > page_limit) ? lim_cand : page_limit;
    avail_wide      = 32'(free_pages_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_head <= '0;
      queue_tail <= '0;
      free_pages <= '0;
      page_limit <= '0;
      clear_cnt  <= '0;
    end else begin
      queue_head <= queue_head_next;
      queue_tail <= queue_tail_next;
      free_pages <= free_pages_next;
      page_limit <= page_limit_next;
      if (cmd.clear_step) clear_cnt <= clear_cnt + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result_address <= addr_c;
      ok             <= ok_c;
      available      <= avail_wide[COUNT_W-1:0];
    end
  end

endmodule : pffl_datapath
`default_nettype wire

### hdl/page_frame_free_list_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// page_frame_free_list_allocator - FIFO free list page frame allocator
// Per-frame state table with a circular free list of page numbers.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request: kind (init, allocate, free, no-op), the page
//   byte address, a page count and an init class. rsp returns one result
//   per request: the allocated byte address, ok and the free page count.
//   A request is taken when req.valid and req.ready are both high; the
//   result is shown on rsp from the edge that commits it. Each request is
//   first captured, reading the state table and free list head, then
//   committed, writing them back and loading the result register.
//   A new request is taken only once the previous one is committed.
//   A new request is taken while the previous result is still held; if
//   rsp stalls, the commit waits, holding state and request until the
//   result register is free.
//   After reset the state table is swept to zero, one entry per cycle,
//   over all NUM_PAGES entries; req.ready stays low during the sweep.
// ----------------------------------------------------------------------------
module page_frame_free_list_allocator import pffl_pkg::*; #(
  parameter int NUM_PAGES = 65536,
  parameter int PAGE_BITS = 12
) (
  input  logic        clk,
  input  logic        rst,
  pffl_req_if.sink    req,
  pffl_rsp_if.source  rsp
);

  ctl_cmd_t   cmd;
  dp_status_t status;

  pffl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .status    (status)
  );

  pffl_datapath #(
    .NUM_PAGES (NUM_PAGES),
    .PAGE_BITS (PAGE_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .kind           (req.kind),
    .phys_address   (req.phys_address),
    .page_count     (req.page_count),
    .page_class     (req.page_class),
    .result_address (rsp.result_address),
    .ok             (rsp.ok),
    .available      (rsp.available)
  );

`ifndef ASSERT_OFF
  a_clear_blocks_req: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_step |-> !req.ready)
    else $error("request taken during clearing pass");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> !req.ready)
    else $error("second request taken before commit");

  a_commit_shows_rsp: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> rsp.valid)
    else $error("commit without result valid");

  a_commit_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!rsp.valid || rsp.ready))
    else $error("result overwritten while stalled");
`endif

endmodule : page_frame_free_list_allocator
`default_nettype wire

### tb/pffl_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pffl_tb_pkg - allocator scoreboard
// Tracks the frame table and the free list as requests are taken, and checks
// each result against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
package pffl_tb_pkg;
  import pffl_pkg::*;

  localparam int NUM_PAGES = 65536;
  localparam int PAGE_BITS = 12;

  typedef struct {
    logic [ADDR_W-1:0]  result_address;
    logic               ok;
    logic [COUNT_W-1:0] available;
  } alloc_result_t;

  class alloc_scoreboard;
    frame_state_t       frame_tab [NUM_PAGES];
    int unsigned        free_ring [NUM_PAGES];
    int unsigned        ring_rd;
    int unsigned        ring_wr;
    logic [COUNT_W-1:0] free_cnt;
    int unsigned        top_page;
    alloc_result_t      due_results [$];
    int unsigned        n_requests;
    int unsigned        n_results;
    int unsigned        n_grants;
    int unsigned        n_returns;
    int unsigned        n_errors;

    function new();
      foreach (frame_tab[i]) frame_tab[i] = FS_FREE;
      ring_rd    = 0;
      ring_wr    = 0;
      free_cnt   = '0;
      top_page   = 0;
      n_requests = 0;
      n_results  = 0;
      n_grants   = 0;
      n_returns  = 0;
      n_errors   = 0;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void list_page(int unsigned pn);
      frame_tab[pn]      = FS_LISTED;
      free_ring[ring_wr] = pn;
      ring_wr            = (ring_wr + 1) % NUM_PAGES;
      free_cnt++;
    endfunction

    function void note_request(kind_t kind, logic [ADDR_W-1:0] addr,
                               logic [COUNT_W-1:0] count, page_class_t cls);
      alloc_result_t want;
      int unsigned   pn;
      pn                  = addr >> PAGE_BITS;
      want.result_address = '0;
      want.ok             = 1'b0;
      case (kind)
        KIND_INIT: begin
          // a listed frame may only be re-initialised as free
          if (pn < NUM_PAGES && cls != CLASS_BAD &&
              (frame_tab[pn] != FS_LISTED || cls == CLASS_FREE)) begin
            want.ok = 1'b1;
            if (frame_tab[pn] != FS_LISTED) begin
              case (cls)
                CLASS_FREE: list_page(pn);
                CLASS_USED: frame_tab[pn] = FS_USED;
                default:    frame_tab[pn] = FS_RESV;
              endcase
            end
            if (pn + 1 > top_page) top_page = pn + 1;
          end
        end
        KIND_ALLOC: begin
          if (count == 1 && free_cnt != 0) begin
            pn                  = free_ring[ring_rd];
            ring_rd             = (ring_rd + 1) % NUM_PAGES;
            free_cnt--;
            frame_tab[pn]       = FS_USED;
            want.result_address = ADDR_W'(pn << PAGE_BITS);
            want.ok             = 1'b1;
            n_grants++;
          end
        end
        KIND_FREE: begin
          if (count == 1 && pn < top_page && pn < NUM_PAGES &&
              (frame_tab[pn] == FS_USED || frame_tab[pn] == FS_RESV)) begin
            list_page(pn);
            want.ok = 1'b1;
            n_returns++;
          end
        end
        default: ;
      endcase
      want.available = free_cnt;
      due_results.push_back(want);
      n_requests++;
    endfunction

    function void check_result(logic [ADDR_W-1:0] addr, logic ok,
                               logic [COUNT_W-1:0] avail);
      alloc_result_t want;
      n_results++;
      if (due_results.size() == 0) begin
        $error("result with no request outstanding: result_address %h ok %b available %0d",
               addr, ok, avail);
        n_errors++;
      end else begin
        want = due_results.pop_front();
        if (addr !== want.result_address) begin
          $error("result_address: expected %h, actual %h", want.result_address, addr);
          n_errors++;
        end
        if (ok !== want.ok) begin
          $error("ok: expected %b, actual %b", want.ok, ok);
          n_errors++;
        end
        if (avail !== want.available) begin
          $error("available: expected %0d, actual %0d", want.available, avail);
          n_errors++;
        end
      end
    endfunction
  endclass

endpackage : pffl_tb_pkg

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - page frame free list allocator testbench
// Directed init, allocate, free and no-op requests followed by random traffic in
// three idling phases, with a long result stall; every result is checked.
// ----------------------------------------------------------------------------
module tb_top;
  import pffl_pkg::*;
  import pffl_tb_pkg::*;

  logic            clk = 1'b0;
  logic            rst;
  int              tx_idle_pct;
  int              rx_idle_pct;
  bit              long_stall_req;
  alloc_scoreboard sb;

  pffl_req_if req ();
  pffl_rsp_if rsp ();

  page_frame_free_list_allocator #(
    .NUM_PAGES(NUM_PAGES),
    .PAGE_BITS(PAGE_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always #4 clk = ~clk;

  task automatic send_request(kind_t kind, logic [ADDR_W-1:0] addr,
                              logic [COUNT_W-1:0] count, page_class_t cls);
    req.valid        <= 1'b1;
    req.kind         <= kind;
    req.phys_address <= addr;
    req.page_count   <= count;
    req.page_class   <= cls;
    do @(posedge clk); while (req.ready !== 1'b1);
    sb.note_request(kind, addr, count, cls);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic run_phase(int n_items, int tx_pct, int rx_pct, bit with_stall);
    int unsigned        pick;
    int unsigned        pn;
    kind_t              kind;
    page_class_t        cls;
    logic [COUNT_W-1:0] count;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int i = 0; i < n_items; i++) begin
      if (with_stall && i == n_items / 4) long_stall_req = 1'b1;
      pick = $urandom_range(0, 99);
      kind = pick < 22 ? KIND_INIT : pick < 58 ? KIND_ALLOC :
             pick < 94 ? KIND_FREE : KIND_NOP;
      pick = $urandom_range(0, 99);
      cls  = pick < 50 ? CLASS_FREE : pick < 72 ? CLASS_USED :
             pick < 92 ? CLASS_RESV : CLASS_BAD;
      pick = $urandom_range(0, 99);
      if (pick < 88) count = 17'd1;
      else if (pick < 92) count = 17'd0;
      else if (pick < 96) count = COUNT_W'($urandom);
      else count = pick[0] ? 17'h10000 : 17'h1ffff;
      // small page pool so frees and re-inits hit live frames
      pick = $urandom_range(0, 99);
      pn   = pick < 88 ? $urandom_range(0, 47) : $urandom_range(0, NUM_PAGES - 1);
      send_request(kind,
                   ADDR_W'((pn << PAGE_BITS) | $urandom_range(0, (1 << PAGE_BITS) - 1)),
                   count, cls);
    end
    drain();
  endtask

  initial begin : rsp_side
    int stall_left;
    stall_left = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
        sb.check_result(rsp.result_address, rsp.ok, rsp.available);
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        stall_left     = 400;
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    sb               = new();
    tx_idle_pct      = 0;
    rx_idle_pct      = 0;
    long_stall_req   = 1'b0;
    rst              <= 1'b1;
    req.valid        <= 1'b0;
    req.kind         <= KIND_NOP;
    req.phys_address <= '0;
    req.page_count   <= '0;
    req.page_class   <= CLASS_FREE;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed requests; ready stays low through the table sweep
    send_request(KIND_ALLOC, 28'h0000000, 17'd1,     CLASS_FREE);
    send_request(KIND_FREE,  28'h0000000, 17'd1,     CLASS_FREE);
    send_request(KIND_INIT,  28'h0000abc, 17'd0,     CLASS_FREE);
    send_request(KIND_INIT,  28'hfffffff, 17'h1ffff, CLASS_FREE);
    send_request(KIND_INIT,  28'h0000000, 17'd1,     CLASS_FREE);
    send_request(KIND_INIT,  28'h0000123, 17'd1,     CLASS_USED);
    send_request(KIND_INIT,  28'h0005000, 17'd1,     CLASS_BAD);
    send_request(KIND_INIT,  28'h0005fff, 17'd1,     CLASS_USED);
    send_request(KIND_INIT,  28'h0006000, 17'd1,     CLASS_RESV);
    send_request(KIND_ALLOC, 28'hfffffff, 17'd0,     CLASS_BAD);
    send_request(KIND_ALLOC, 28'h0000000, 17'd2,     CLASS_FREE);
    send_request(KIND_ALLOC, 28'h0000000, 17'h10000, CLASS_FREE);
    send_request(KIND_ALLOC, 28'h0000000, 17'h1ffff, CLASS_FREE);
    send_request(KIND_ALLOC, 28'h0000000, 17'd1,     CLASS_FREE);
    send_request(KIND_FREE,  28'h0005000, 17'd2,     CLASS_FREE);
    send_request(KIND_FREE,  28'h0005000, 17'd1,     CLASS_FREE);
    send_request(KIND_FREE,  28'h0006abc, 17'd1,     CLASS_RESV);
    send_request(KIND_FREE,  28'h0006000, 17'd1,     CLASS_FREE);
    send_request(KIND_FREE,  28'h0008000, 17'd1,     CLASS_FREE);
    send_request(KIND_NOP,   28'hfffffff, 17'd1,     CLASS_BAD);
    send_request(KIND_ALLOC, 28'h0000000, 17'd1,     CLASS_FREE);
    send_request(KIND_ALLOC, 28'h0000000, 17'd1,     CLASS_FREE);
    send_request(KIND_ALLOC, 28'h0000000, 17'd1,     CLASS_FREE);
    send_request(KIND_ALLOC, 28'h0000000, 17'd1,     CLASS_FREE);
    send_request(KIND_FREE,  28'hffff000, 17'd1,     CLASS_FREE);
    drain();

    run_phase(200, 20, 62, 1'b0);
    run_phase(200, 62, 20, 1'b0);
    run_phase(200, 0, 0, 1'b1);

    repeat (8) @(posedge clk);
    $display("Covered %0d requests: %0d pages granted, %0d pages returned to the list.",
             sb.n_requests, sb.n_grants, sb.n_returns);
    $display("%0d results checked, %0d mismatches, %0d still outstanding.",
             sb.n_results, sb.n_errors, sb.pending());
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule : tb_top
